FILE: hdl/telemetry_frame_receiver_assert.svh
// Assertion macros for the telemetry frame receiver checker.
// Depends on a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef TELEMETRY_FRAME_RECEIVER_ASSERT_SVH
`define TELEMETRY_FRAME_RECEIVER_ASSERT_SVH

// Same-cycle implication, held off while reset is low.
`define TFR_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("telemetry_frame_receiver: implication check failed");

// Next-cycle implication, held off while reset is low.
`define TFR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("telemetry_frame_receiver: next-cycle check failed");

// Next-cycle implication that also covers reset itself.
`define TFR_ASSERT_RESET(label, ante, cons) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("telemetry_frame_receiver: reset check failed");

`endif

FILE: hdl/tfr_pkg.sv
// Types, constants and helper functions for the telemetry frame receiver.
// No dependencies.
`timescale 1ns / 1ps

package tfr_pkg;

    typedef enum logic [2:0] {
        PH_WAIT,
        PH_LEN,
        PH_TYPE,
        PH_DATA,
        PH_CRCH,
        PH_CRCL
    } t_phase;

    localparam logic [7:0]  START_BYTE      = 8'h02;
    localparam logic [7:0]  TYPE_GET_VALUES = 8'h04;
    localparam logic [7:0]  FAULT_OFFSET    = 8'd52;
    localparam int          RPM_OFFSET      = 22;
    localparam int          VOLT_OFFSET     = 26;
    localparam int          CONS_OFFSET     = 28;
    localparam int          SHADOW_DEPTH    = 32;
    localparam int          SHADOW_AW       = $clog2(SHADOW_DEPTH);
    localparam logic [15:0] CRC_POLY        = 16'h1021;

    typedef struct packed {
        logic        frame_end;
        logic        crc_match;
        logic [7:0]  packet_type;
        logic [15:0] fet_temperature;
        logic [15:0] motor_temperature;
        logic [30:0] motor_current_mag;
        logic [30:0] input_current_mag;
        logic [30:0] rpm_mag;
        logic [15:0] supply_voltage;
        logic [31:0] charge_consumed;
        logic [7:0]  fault_code;
        logic [15:0] good_packet_count;
    } t_result;

    // CRC16-CCITT, MSB first, one byte per call
    function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

    // Magnitude of a two's complement word; the most negative value saturates
    function automatic logic [30:0] mag31(input logic [31:0] v);
        logic [31:0] m;
        m = ~v + 32'd1;
        if (!v[31]) begin
            return v[30:0];
        end
        return m[31] ? {31{1'b1}} : m[30:0];
    endfunction

endpackage

FILE: hdl/telemetry_frame_receiver.sv
// Framed serial packet parser with CRC16-CCITT check and telemetry latch.
// Depends on tfr_pkg.
`timescale 1ns / 1ps

// Usage:
// Input channel (i_valid / o_ready / i_rx_byte) carries one received serial byte per
// transaction. The parser hunts for the start byte, then reads length, type, payload
// and a big-endian CRC16 computed over type and payload.
// Output channel (o_valid / i_ready / o_*) returns exactly one result per input byte:
// frame_end and crc_match flag the final CRC byte, the other fields show the frame
// type, the latched telemetry of the last good get-values frame and the good packet
// count, all as they stand after that byte.
// Each accepted byte's result is registered: into the output register, or into the skid register while it stalls.
// Throughput: one byte per cycle while o_ready is high; the parse step, CRC byte update
// and field latch all sit between the parser state registers and the result register.
// A two-entry output stage (result register plus skid register) keeps o_ready
// registered; when the receiver stalls, one more byte is taken into the skid
// register and then o_ready drops until the receiver takes the waiting result.
// Reset (synchronous, active low) returns the parser to hunting, clears the
// telemetry fields, the counter and both output entries. Payload shadow bytes are
// not cleared; fields of a short get-values frame read whatever earlier frames left.
module telemetry_frame_receiver (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_rx_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_frame_end,
    output logic        o_crc_match,
    output logic [7:0]  o_packet_type,
    output logic [15:0] o_fet_temperature,
    output logic [15:0] o_motor_temperature,
    output logic [30:0] o_motor_current_mag,
    output logic [30:0] o_input_current_mag,
    output logic [30:0] o_rpm_mag,
    output logic [15:0] o_supply_voltage,
    output logic [31:0] o_charge_consumed,
    output logic [7:0]  o_fault_code,
    output logic [15:0] o_good_packet_count
);
    import tfr_pkg::*;

    // parser state
    t_phase      r_phase, n_phase;
    logic [7:0]  r_remaining, n_remaining;
    logic [7:0]  r_index, n_index;
    logic [15:0] r_crc, n_crc;
    logic [7:0]  r_crc_hi, n_crc_hi;
    logic [7:0]  r_type, n_type;
    logic [15:0] r_count, n_count;

    // latched telemetry
    logic [15:0] r_fet, n_fet;
    logic [15:0] r_motor_t, n_motor_t;
    logic [30:0] r_motor_i, n_motor_i;
    logic [30:0] r_input_i, n_input_i;
    logic [30:0] r_rpm, n_rpm;
    logic [15:0] r_volt, n_volt;
    logic [31:0] r_cons, n_cons;
    logic [7:0]  r_fault, n_fault;

    // payload shadow, no reset
    logic [7:0]  r_shadow [SHADOW_DEPTH];
    logic [7:0]  r_fault_shadow;

    // output stage
    logic        r_out_valid;
    t_result     r_out;
    logic        r_skid_valid;
    t_result     r_skid;

    logic        accept_in;
    logic        take_out;
    logic [7:0]  rem_dec;
    logic [7:0]  rem_minus;
    logic        crc_ok;
    logic        do_latch;
    t_result     new_result;

    assign o_ready   = !r_skid_valid;
    assign accept_in = i_valid && o_ready;
    assign take_out  = r_out_valid && i_ready;

    assign rem_dec   = (r_remaining != 8'd0) ? (r_remaining - 8'd1) : 8'd0;
    assign rem_minus = r_remaining - 8'd1;
    assign crc_ok    = (r_phase == PH_CRCL) && (r_crc == {r_crc_hi, i_rx_byte});
    assign do_latch  = crc_ok && (r_type == TYPE_GET_VALUES);

    // next phase
    always_comb begin
        unique case (r_phase)
            PH_WAIT: n_phase = (i_rx_byte == START_BYTE) ? PH_LEN : PH_WAIT;
            PH_LEN:  n_phase = PH_TYPE;
            PH_TYPE: n_phase = (rem_dec == 8'd0) ? PH_CRCH : PH_DATA;
            PH_DATA: n_phase = (rem_minus == 8'd0) ? PH_CRCH : PH_DATA;
            PH_CRCH: n_phase = PH_CRCL;
            PH_CRCL: n_phase = PH_WAIT;
            default: n_phase = PH_WAIT;
        endcase
    end

    // parser datapath
    always_comb begin
        n_remaining = r_remaining;
        n_index     = r_index;
        n_crc       = r_crc;
        n_crc_hi    = r_crc_hi;
        n_type      = r_type;
        unique case (r_phase)
            PH_LEN: begin
                n_remaining = i_rx_byte;
                n_crc       = 16'h0000;
            end
            PH_TYPE: begin
                n_remaining = rem_dec;
                n_crc       = crc16_step(r_crc, i_rx_byte);
                n_type      = i_rx_byte;
                n_index     = 8'd0;
            end
            PH_DATA: begin
                n_remaining = rem_minus;
                n_crc       = crc16_step(r_crc, i_rx_byte);
                n_index     = r_index + 8'd1;
            end
            PH_CRCH: begin
                n_crc_hi = i_rx_byte;
            end
            default: begin
                n_crc_hi = r_crc_hi;
            end
        endcase
    end

    // telemetry latch and good packet count
    always_comb begin
        n_fet     = r_fet;
        n_motor_t = r_motor_t;
        n_motor_i = r_motor_i;
        n_input_i = r_input_i;
        n_rpm     = r_rpm;
        n_volt    = r_volt;
        n_cons    = r_cons;
        n_fault   = r_fault;
        n_count   = crc_ok ? (r_count + 16'd1) : r_count;
        if (do_latch) begin
            n_fet     = {r_shadow[0], r_shadow[1]};
            n_motor_t = {r_shadow[2], r_shadow[3]};
            n_motor_i = mag31({r_shadow[4], r_shadow[5], r_shadow[6], r_shadow[7]});
            n_input_i = mag31({r_shadow[8], r_shadow[9], r_shadow[10], r_shadow[11]});
            n_rpm     = mag31({r_shadow[RPM_OFFSET],     r_shadow[RPM_OFFSET + 1],
                               r_shadow[RPM_OFFSET + 2], r_shadow[RPM_OFFSET + 3]});
            n_volt    = {r_shadow[VOLT_OFFSET], r_shadow[VOLT_OFFSET + 1]};
            n_cons    = {r_shadow[CONS_OFFSET],     r_shadow[CONS_OFFSET + 1],
                         r_shadow[CONS_OFFSET + 2], r_shadow[CONS_OFFSET + 3]};
            n_fault   = r_fault_shadow;
        end
    end

    always_comb begin
        new_result.frame_end         = (r_phase == PH_CRCL);
        new_result.crc_match         = crc_ok;
        new_result.packet_type       = n_type;
        new_result.fet_temperature   = n_fet;
        new_result.motor_temperature = n_motor_t;
        new_result.motor_current_mag = n_motor_i;
        new_result.input_current_mag = n_input_i;
        new_result.rpm_mag           = n_rpm;
        new_result.supply_voltage    = n_volt;
        new_result.charge_consumed   = n_cons;
        new_result.fault_code        = n_fault;
        new_result.good_packet_count = n_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_WAIT;
            r_remaining <= 8'd0;
            r_index     <= 8'd0;
            r_crc       <= 16'h0000;
            r_crc_hi    <= 8'd0;
            r_type      <= 8'd0;
            r_count     <= 16'd0;
            r_fet       <= 16'd0;
            r_motor_t   <= 16'd0;
            r_motor_i   <= 31'd0;
            r_input_i   <= 31'd0;
            r_rpm       <= 31'd0;
            r_volt      <= 16'd0;
            r_cons      <= 32'd0;
            r_fault     <= 8'd0;
        end else if (accept_in) begin
            r_phase     <= n_phase;
            r_remaining <= n_remaining;
            r_index     <= n_index;
            r_crc       <= n_crc;
            r_crc_hi    <= n_crc_hi;
            r_type      <= n_type;
            r_count     <= n_count;
            r_fet       <= n_fet;
            r_motor_t   <= n_motor_t;
            r_motor_i   <= n_motor_i;
            r_input_i   <= n_input_i;
            r_rpm       <= n_rpm;
            r_volt      <= n_volt;
            r_cons      <= n_cons;
            r_fault     <= n_fault;
        end
    end

    // keep payload offsets 0 to 31 and the fault code offset; not every kept offset feeds a field
    always_ff @(posedge i_clk) begin
        if (accept_in && (r_phase == PH_DATA)) begin
            if (r_index < 8'(SHADOW_DEPTH)) begin
                r_shadow[r_index[SHADOW_AW-1:0]] <= i_rx_byte;
            end else if (r_index == FAULT_OFFSET) begin
                r_fault_shadow <= i_rx_byte;
            end
        end
    end

    // output register with skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (take_out || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= accept_in;
            end
        end else if (accept_in) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_out || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (accept_in) begin
                r_out <= new_result;
            end
        end else if (accept_in) begin
            r_skid <= new_result;
        end
    end

    assign o_valid             = r_out_valid;
    assign o_frame_end         = r_out.frame_end;
    assign o_crc_match         = r_out.crc_match;
    assign o_packet_type       = r_out.packet_type;
    assign o_fet_temperature   = r_out.fet_temperature;
    assign o_motor_temperature = r_out.motor_temperature;
    assign o_motor_current_mag = r_out.motor_current_mag;
    assign o_input_current_mag = r_out.input_current_mag;
    assign o_rpm_mag           = r_out.rpm_mag;
    assign o_supply_voltage    = r_out.supply_voltage;
    assign o_charge_consumed   = r_out.charge_consumed;
    assign o_fault_code        = r_out.fault_code;
    assign o_good_packet_count = r_out.good_packet_count;

endmodule

FILE: hdl/tfr_checker.sv
// Port-level checker for the telemetry frame receiver, bound to the top level.
// Depends on telemetry_frame_receiver_assert.svh.
`timescale 1ns / 1ps

`include "telemetry_frame_receiver_assert.svh"

module tfr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic        o_frame_end,
    input logic        o_crc_match,
    input logic [15:0] o_good_packet_count
);

    // a match is only reported on the closing CRC byte
    `TFR_ASSERT_IMPL(a_match_needs_end, o_valid && o_crc_match, o_frame_end)

    // a frame spans at least five bytes, so two frame ends never follow each other
    `TFR_ASSERT_NEXT(a_no_back_to_back_end, o_valid && i_ready && o_frame_end,
                     !(o_valid && o_frame_end))

    // stalled transaction holds
    `TFR_ASSERT_NEXT(a_stall_holds, o_valid && !i_ready,
                     o_valid && $stable(o_good_packet_count))

    // reset empties the output stage
    `TFR_ASSERT_RESET(a_reset_empty, !i_rst_n, !o_valid && o_ready)

endmodule

bind telemetry_frame_receiver tfr_checker u_tfr_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .o_ready             (o_ready),
    .o_valid             (o_valid),
    .i_ready             (i_ready),
    .o_frame_end         (o_frame_end),
    .o_crc_match         (o_crc_match),
    .o_good_packet_count (o_good_packet_count)
);

FILE: tb/tb_telemetry_frame_receiver.sv
// Self-checking testbench for telemetry_frame_receiver: frames and noise bytes in,
// one result per byte out, each checked against a cycle-free parser predictor.
// Depends on tfr_pkg and telemetry_frame_receiver.
`timescale 1ns / 1ps

module tb_telemetry_frame_receiver;
    import tfr_pkg::*;

    localparam int RANDOM_BYTES = 1100;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 16;
    localparam int HOLD_CYCLES  = 64;
    localparam int MAX_REPORTS  = 10;

    typedef enum logic [2:0] {FILL_ZERO, FILL_ONES, FILL_MINNEG, FILL_RAND, FILL_EDGE} t_fill;
    typedef enum logic [1:0] {CRC_OK, CRC_BAD_HI, CRC_BAD_LO} t_crc_mode;

    // One directed row: a lone byte, or a whole frame whose length byte is head
    typedef struct packed {
        logic        is_frame;
        logic [7:0]  head;
        logic [7:0]  ftype;
        t_fill       fill;
        t_crc_mode   crc_mode;
        logic        typed;
        logic        t_end;
        logic        t_match;
        logic [15:0] t_count;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [7:0]  i_rx_byte;
    logic        o_valid;
    logic        i_ready;
    logic        o_frame_end;
    logic        o_crc_match;
    logic [7:0]  o_packet_type;
    logic [15:0] o_fet_temperature;
    logic [15:0] o_motor_temperature;
    logic [30:0] o_motor_current_mag;
    logic [30:0] o_input_current_mag;
    logic [30:0] o_rpm_mag;
    logic [15:0] o_supply_voltage;
    logic [31:0] o_charge_consumed;
    logic [7:0]  o_fault_code;
    logic [15:0] o_good_packet_count;

    telemetry_frame_receiver i_dut (.*);

    // The first full-length frame writes every kept payload offset, so no later
    // latch can read a byte that was never written.
    t_row plan [14] = '{
        '{1'b0, 8'h00, 8'h00, FILL_ZERO,   CRC_OK,     1'b1, 1'b0, 1'b0, 16'd0},
        '{1'b0, 8'hFF, 8'h00, FILL_ZERO,   CRC_OK,     1'b1, 1'b0, 1'b0, 16'd0},
        '{1'b1, 8'd54, 8'h04, FILL_ONES,   CRC_OK,     1'b1, 1'b1, 1'b1, 16'd1},
        '{1'b1, 8'd54, 8'h04, FILL_MINNEG, CRC_OK,     1'b1, 1'b1, 1'b1, 16'd2},
        '{1'b1, 8'd54, 8'h04, FILL_ZERO,   CRC_OK,     1'b1, 1'b1, 1'b1, 16'd3},
        '{1'b1, 8'd54, 8'h04, FILL_ONES,   CRC_BAD_HI, 1'b1, 1'b1, 1'b0, 16'd3},
        '{1'b1, 8'd54, 8'h04, FILL_RAND,   CRC_BAD_LO, 1'b1, 1'b1, 1'b0, 16'd3},
        '{1'b1, 8'd1,  8'h04, FILL_RAND,   CRC_OK,     1'b1, 1'b1, 1'b1, 16'd4},
        '{1'b1, 8'd0,  8'h00, FILL_RAND,   CRC_OK,     1'b1, 1'b1, 1'b1, 16'd5},
        '{1'b1, 8'd255, 8'hFF, FILL_RAND,  CRC_OK,     1'b0, 1'b0, 1'b0, 16'd0},
        '{1'b1, 8'd20, 8'h04, FILL_EDGE,   CRC_OK,     1'b0, 1'b0, 1'b0, 16'd0},
        '{1'b1, 8'd53, 8'h04, FILL_RAND,   CRC_OK,     1'b0, 1'b0, 1'b0, 16'd0},
        '{1'b0, 8'h03, 8'h00, FILL_ZERO,   CRC_OK,     1'b0, 1'b0, 1'b0, 16'd0},
        '{1'b0, 8'h02, 8'h00, FILL_ZERO,   CRC_OK,     1'b0, 1'b0, 1'b0, 16'd0}
    };

    // Parser predictor state
    t_phase      rx_phase   = PH_WAIT;
    logic [7:0]  bytes_left = '0;
    logic [7:0]  pay_idx    = '0;
    logic [15:0] crc_acc    = '0;
    logic [15:0] crc_rx     = '0;
    logic [7:0]  cur_type   = '0;
    logic [15:0] good_count = '0;
    logic [7:0]  shadow_bytes [SHADOW_DEPTH + 1];
    t_result     held       = '0;

    t_result pending_results [$];
    int      mismatches        = 0;
    int      results_seen      = 0;
    int      frame_bytes       = 0;
    int      cycle_count       = 0;
    int      sender_idle_pct   = 23;
    int      receiver_idle_pct = 63;
    bit      hold_request      = 1'b0;

    function automatic logic [15:0] ccitt_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int k = 7; k >= 0; k--) begin
            fb = c[15] ^ b[k];
            c  = {c[14:0], 1'b0};
            if (fb) begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

    function automatic logic [30:0] abs_sat31(input logic [31:0] v);
        logic [31:0] neg;
        neg = 32'd0 - v;
        if (!v[31]) begin
            return v[30:0];
        end
        return neg[31] ? {31{1'b1}} : neg[30:0];
    endfunction

    function automatic logic [31:0] shadow_word(input logic [5:0] off);
        return {shadow_bytes[off], shadow_bytes[off + 6'd1], shadow_bytes[off + 6'd2],
                shadow_bytes[off + 6'd3]};
    endfunction

    // Advance the parser by one byte and return the result it shows after it
    function automatic t_result decode_rx_byte(input logic [7:0] b);
        t_result r;
        r = held;
        r.frame_end = 1'b0;
        r.crc_match = 1'b0;
        case (rx_phase)
            PH_WAIT: begin
                if (b == START_BYTE) begin
                    rx_phase = PH_LEN;
                end
            end
            PH_LEN: begin
                bytes_left = b;
                crc_acc    = '0;
                rx_phase   = PH_TYPE;
            end
            PH_TYPE: begin
                if (bytes_left != 0) begin
                    bytes_left = bytes_left - 8'd1;
                end
                crc_acc  = ccitt_update(crc_acc, b);
                cur_type = b;
                pay_idx  = '0;
                rx_phase = (bytes_left == 0) ? PH_CRCH : PH_DATA;
            end
            PH_DATA: begin
                crc_acc = ccitt_update(crc_acc, b);
                if (pay_idx < SHADOW_DEPTH) begin
                    shadow_bytes[pay_idx[5:0]] = b;
                end else if (pay_idx == FAULT_OFFSET) begin
                    shadow_bytes[SHADOW_DEPTH] = b;
                end
                pay_idx    = pay_idx + 8'd1;
                bytes_left = bytes_left - 8'd1;
                if (bytes_left == 0) begin
                    rx_phase = PH_CRCH;
                end
            end
            PH_CRCH: begin
                crc_rx   = {b, 8'h00};
                rx_phase = PH_CRCL;
            end
            PH_CRCL: begin
                crc_rx[7:0] = b;
                r.frame_end = 1'b1;
                if (crc_acc == crc_rx) begin
                    r.crc_match = 1'b1;
                    if (cur_type == TYPE_GET_VALUES) begin
                        held.fet_temperature   = {shadow_bytes[0], shadow_bytes[1]};
                        held.motor_temperature = {shadow_bytes[2], shadow_bytes[3]};
                        held.motor_current_mag = abs_sat31(shadow_word(6'd4));
                        held.input_current_mag = abs_sat31(shadow_word(6'd8));
                        held.rpm_mag           = abs_sat31(shadow_word(6'(RPM_OFFSET)));
                        held.supply_voltage    = {shadow_bytes[VOLT_OFFSET],
                                                  shadow_bytes[VOLT_OFFSET + 1]};
                        held.charge_consumed   = shadow_word(6'(CONS_OFFSET));
                        held.fault_code        = shadow_bytes[SHADOW_DEPTH];
                    end
                    good_count = good_count + 16'd1;
                end
                rx_phase = PH_WAIT;
            end
            default: rx_phase = PH_WAIT;
        endcase
        r.fet_temperature   = held.fet_temperature;
        r.motor_temperature = held.motor_temperature;
        r.motor_current_mag = held.motor_current_mag;
        r.input_current_mag = held.input_current_mag;
        r.rpm_mag           = held.rpm_mag;
        r.supply_voltage    = held.supply_voltage;
        r.charge_consumed   = held.charge_consumed;
        r.fault_code        = held.fault_code;
        r.packet_type       = cur_type;
        r.good_packet_count = good_count;
        return r;
    endfunction

    function automatic logic [7:0] fill_byte(input t_fill fill, input int i);
        case (fill)
            FILL_ZERO:   return 8'h00;
            FILL_ONES:   return 8'hFF;
            FILL_MINNEG: return (i == 4 || i == 8 || i == RPM_OFFSET) ? 8'h80 : 8'h00;
            FILL_EDGE: begin
                case ($urandom_range(3))
                    0:       return 8'h00;
                    1:       return 8'h7F;
                    2:       return 8'h80;
                    default: return 8'hFF;
                endcase
            end
            default:     return 8'($urandom);
        endcase
    endfunction

    // Offer one byte, hold it until the transaction completes, then queue its result
    task automatic send_byte(input logic [7:0] b, input logic typed, input logic t_end,
                             input logic t_match, input logic [15:0] t_count);
        t_result want;
        while ($urandom_range(99) < sender_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_rx_byte <= b;
        do @(posedge i_clk); while (!o_ready);
        want = decode_rx_byte(b);
        if (typed) begin
            want.frame_end         = t_end;
            want.crc_match         = t_match;
            want.good_packet_count = t_count;
        end
        pending_results.push_back(want);
    endtask

    // Build start, length, type, payload and CRC; optionally corrupt or cut short
    task automatic send_frame(input logic [7:0] len, input logic [7:0] ftype,
                              input t_fill fill, input t_crc_mode crc_mode, input int cut,
                              input logic typed, input logic t_end, input logic t_match,
                              input logic [15:0] t_count);
        logic [7:0]  body [$];
        logic [7:0]  b;
        logic [15:0] crc;
        int          n_pay;
        int          n_send;
        n_pay = (len == 0) ? 0 : int'(len) - 1;
        body.push_back(START_BYTE);
        body.push_back(len);
        body.push_back(ftype);
        crc = ccitt_update(16'h0000, ftype);
        for (int i = 0; i < n_pay; i++) begin
            b = fill_byte(fill, i);
            body.push_back(b);
            crc = ccitt_update(crc, b);
        end
        case (crc_mode)
            CRC_BAD_HI: crc[15:8] = crc[15:8] ^ 8'($urandom_range(1, 255));
            CRC_BAD_LO: crc[7:0]  = crc[7:0] ^ 8'($urandom_range(1, 255));
            default: ;
        endcase
        body.push_back(crc[15:8]);
        body.push_back(crc[7:0]);
        n_send = (cut > 0 && cut < body.size()) ? cut : body.size();
        frame_bytes += n_send;
        for (int i = 0; i < n_send; i++) begin
            send_byte(body[i], typed && (i == n_send - 1), t_end, t_match, t_count);
        end
    endtask

    task automatic send_random_chunk();
        int         pick;
        int         len;
        int         cut;
        logic [7:0] ftype;
        t_crc_mode  mode;
        t_fill      fill;
        pick = $urandom_range(99);
        if (pick < 12) begin
            // Noise: mostly ignored while hunting, a start byte opens a stray frame
            repeat ($urandom_range(1, 4)) begin
                send_byte(($urandom_range(3) == 0) ? START_BYTE : 8'($urandom),
                          1'b0, 1'b0, 1'b0, 16'd0);
                frame_bytes += 1;
            end
            return;
        end
        pick = $urandom_range(99);
        if (pick < 6) begin
            len = $urandom_range(1);
        end else if (pick < 10) begin
            len = $urandom_range(200, 255);
        end else if (pick < 45) begin
            len = $urandom_range(54, 60);
        end else begin
            len = $urandom_range(2, 53);
        end
        ftype = $urandom_range(1) ? TYPE_GET_VALUES : 8'($urandom);
        pick  = $urandom_range(99);
        mode  = (pick < 10) ? CRC_BAD_HI : (pick < 20) ? CRC_BAD_LO : CRC_OK;
        fill  = ($urandom_range(4) == 0) ? FILL_EDGE : FILL_RAND;
        cut   = ($urandom_range(99) < 8) ? $urandom_range(1, len + 3) : 0;
        send_frame(8'(len), ftype, fill, mode, cut, 1'b0, 1'b0, 1'b0, 16'd0);
    endtask

    task automatic show_field(input string name, input logic [31:0] want,
                              input logic [31:0] seen);
        if (want !== seen) begin
            $display("    %s: expected 0x%0h, got 0x%0h", name, want, seen);
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("telemetry_frame_receiver regression: fail");
            $finish;
        end
    end

    // Result side: random stalls, plus one long hold-off to back the block up
    initial begin
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                for (int k = 0; k < HOLD_CYCLES; k++) begin
                    i_ready <= 1'b0;
                    @(posedge i_clk);
                end
            end
            i_ready <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_result seen;
        t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            seen = {o_frame_end, o_crc_match, o_packet_type, o_fet_temperature,
                    o_motor_temperature, o_motor_current_mag, o_input_current_mag,
                    o_rpm_mag, o_supply_voltage, o_charge_consumed, o_fault_code,
                    o_good_packet_count};
            results_seen++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("result %0d: no byte outstanding for it", results_seen);
                end
            end else begin
                want = pending_results.pop_front();
                if (seen !== want) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("result %0d mismatch:", results_seen);
                        show_field("frame_end", 32'(want.frame_end), 32'(seen.frame_end));
                        show_field("crc_match", 32'(want.crc_match), 32'(seen.crc_match));
                        show_field("packet_type", 32'(want.packet_type),
                                   32'(seen.packet_type));
                        show_field("fet_temperature", 32'(want.fet_temperature),
                                   32'(seen.fet_temperature));
                        show_field("motor_temperature", 32'(want.motor_temperature),
                                   32'(seen.motor_temperature));
                        show_field("motor_current_mag", 32'(want.motor_current_mag),
                                   32'(seen.motor_current_mag));
                        show_field("input_current_mag", 32'(want.input_current_mag),
                                   32'(seen.input_current_mag));
                        show_field("rpm_mag", 32'(want.rpm_mag), 32'(seen.rpm_mag));
                        show_field("supply_voltage", 32'(want.supply_voltage),
                                   32'(seen.supply_voltage));
                        show_field("charge_consumed", want.charge_consumed,
                                   seen.charge_consumed);
                        show_field("fault_code", 32'(want.fault_code),
                                   32'(seen.fault_code));
                        show_field("good_packet_count", 32'(want.good_packet_count),
                                   32'(seen.good_packet_count));
                    end
                end
            end
        end
    end

    // Byte side: reset, directed table, random frames, then drain
    initial begin
        i_rst_n   <= 1'b0;
        i_valid   <= 1'b0;
        i_rx_byte <= 8'h00;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[r]) begin
            if (plan[r].is_frame) begin
                send_frame(plan[r].head, plan[r].ftype, plan[r].fill, plan[r].crc_mode, 0,
                           plan[r].typed, plan[r].t_end, plan[r].t_match, plan[r].t_count);
            end else begin
                send_byte(plan[r].head, plan[r].typed, plan[r].t_end, plan[r].t_match,
                          plan[r].t_count);
            end
        end

        frame_bytes = 0;
        while (frame_bytes < RANDOM_BYTES) begin
            if (frame_bytes >= (2 * RANDOM_BYTES) / 3) begin
                if (sender_idle_pct != 0 || receiver_idle_pct != 0) begin
                    hold_request = 1'b1;
                end
                sender_idle_pct   = 0;
                receiver_idle_pct = 0;
            end else if (frame_bytes >= RANDOM_BYTES / 3) begin
                sender_idle_pct   = 63;
                receiver_idle_pct = 23;
            end
            send_random_chunk();
        end
        i_valid <= 1'b0;

        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("telemetry_frame_receiver regression: pass");
        end else begin
            $display("telemetry_frame_receiver regression: fail");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/tfr_pkg.sv
hdl/telemetry_frame_receiver.sv
hdl/tfr_checker.sv
tb/tb_telemetry_frame_receiver.sv
